>>> sv/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg
// Request and response types, operation and status codes shared by the
// circular fifo with search.
// ----------------------------------------------------------------------------
`default_nettype none

package fcs_pkg;

    localparam int CAP_W  = 5;
    localparam int WORD_W = 64;

    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_DEQUEUE = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_SEARCH  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]        operation;
        logic [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] data;
        logic [3:0]        position;
        logic [CAP_W-1:0]  count;
    } rsp_t;

endpackage : fcs_pkg

`default_nettype wire

>>> sv/fcs_ram.sv
// ----------------------------------------------------------------------------
// fcs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : fcs_ram

`default_nettype wire

>>> sv/fcs_ctrl.sv
// ----------------------------------------------------------------------------
// fcs_ctrl
// Queue sequencer: keeps head and fill, drives the word memory, walks the
// stored entries for a search and hands each response to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire fcs_pkg::req_t              req,
    input  wire logic [fcs_pkg::CAP_W-1:0]  cap,
    input  wire logic                       cfg_we,
    output logic                            ram_we,
    output logic      [AW-1:0]              ram_waddr,
    output logic      [fcs_pkg::WORD_W-1:0] ram_wdata,
    output logic      [AW-1:0]              ram_raddr,
    input  wire logic [fcs_pkg::WORD_W-1:0] ram_rdata,
    input  wire logic                       out_free,
    output logic                            res_valid,
    output fcs_pkg::rsp_t                   res
);

    import fcs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   head_reg, head_next;
    logic [CAP_W-1:0]   fill_reg, fill_next;
    logic [CAP_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [CAP_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [WORD_W-1:0]  key_reg, key_next;
    rsp_t               hold_reg, hold_next;

    logic               accept;
    logic               fin;
    rsp_t               fin_rsp;
    logic [CAP_W:0]     tail_sum;
    logic [CAP_W-1:0]   tail;
    logic [CAP_W-1:0]   head_inc;
    logic [CAP_W-1:0]   scan_addr_inc;
    logic [CAP_W-1:0]   scan_idx_inc;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    // slot behind the newest word, wrapped at the capacity
    assign tail_sum = {1'b0, head_reg} + {1'b0, fill_reg};
    assign tail     = (tail_sum >= {1'b0, cap}) ? CAP_W'(tail_sum - {1'b0, cap})
                                                : CAP_W'(tail_sum);

    assign head_inc      = (head_reg + CAP_W'(1) == cap) ? '0 : head_reg + CAP_W'(1);
    assign scan_addr_inc = (scan_addr_reg + CAP_W'(1) == cap) ? '0
                                                              : scan_addr_reg + CAP_W'(1);
    assign scan_idx_inc  = scan_idx_reg + CAP_W'(1);

    assign ram_waddr = AW'(tail);
    assign ram_wdata = req.value;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        scan_idx_next  = scan_idx_reg;
        scan_addr_next = scan_addr_reg;
        key_next       = key_reg;
        hold_next      = hold_reg;
        ram_we         = 1'b0;
        ram_raddr      = AW'(head_reg);
        fin            = 1'b0;
        fin_rsp        = '0;
        res_valid      = 1'b0;
        res            = hold_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    head_next = '0;
                    fill_next = '0;
                end
                else if (accept)
                begin
                    unique case (req.operation)
                        OP_ENQUEUE:
                        begin
                            fin = 1'b1;
                            if (fill_reg >= cap)
                            begin
                                fin_rsp.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + CAP_W'(1);
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (fill_reg == '0)
                            begin
                                fin            = 1'b1;
                                fin_rsp.status = ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                fill_next  = fill_reg - CAP_W'(1);
                                state_next = S_READ;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (fill_reg == '0)
                            begin
                                fin            = 1'b1;
                                fin_rsp.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            fin       = 1'b1;
                            head_next = '0;
                            fill_next = '0;
                        end
                        OP_SEARCH:
                        begin
                            if (fill_reg == '0)
                            begin
                                fin            = 1'b1;
                                fin_rsp.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                key_next       = req.value;
                                scan_idx_next  = '0;
                                scan_addr_next = head_reg;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                fin          = 1'b1;
                fin_rsp.data = ram_rdata;
            end
            S_SCAN:
            begin
                // ram_rdata holds the entry at offset scan_idx_reg
                if (ram_rdata == key_reg)
                begin
                    fin              = 1'b1;
                    fin_rsp.position = scan_idx_reg[3:0];
                end
                else if (scan_idx_inc == fill_reg)
                begin
                    fin            = 1'b1;
                    fin_rsp.status = ST_NOT_FOUND;
                end
                else
                begin
                    scan_idx_next  = scan_idx_inc;
                    scan_addr_next = scan_addr_inc;
                    ram_raddr      = AW'(scan_addr_inc);
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            fin_rsp.count = fill_next;
            res           = fin_rsp;
            if (out_free)
            begin
                res_valid  = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                hold_next  = fin_rsp;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            scan_idx_reg  <= '0;
            scan_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            scan_idx_reg  <= scan_idx_next;
            scan_addr_reg <= scan_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        hold_reg <= hold_next;
    end

endmodule : fcs_ctrl

`default_nettype wire

>>> sv/circular_fifo_with_search.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// Circular queue of 64-bit words with enqueue, dequeue, peek, clear and search.
// ----------------------------------------------------------------------------
// One request is worked on at a time and gives exactly one response. Enqueue,
// clear, a rejected request and an unknown operation are answered from the
// idle state; dequeue and peek wait for the registered read of the word
// memory; a search compares the stored entries in turn from the head (up to
// the count), since the memory's single read port yields one stored word per
// cycle. The response sits in an output register, so the next request is
// taken while it waits; a further finished response is parked until that
// register frees up. Writing cfg_wdata sets the capacity (zero acts as one,
// values above DEPTH act as DEPTH) and empties the queue; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_with_search #(
    parameter int DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire fcs_pkg::req_t             req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output fcs_pkg::rsp_t                  rsp,
    input  wire logic                      cfg_we,
    input  wire logic [fcs_pkg::CAP_W-1:0] cfg_wdata
);

    import fcs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CAP_W-1:0] CAP_MAX   = (DEPTH > 31) ? CAP_W'(31) : CAP_W'(DEPTH);
    localparam logic [CAP_W-1:0] RESET_CAP = (CAP_MAX < CAP_W'(16)) ? CAP_MAX
                                                                     : CAP_W'(16);

    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;
    logic              out_free;
    logic              res_valid;
    rsp_t              res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                cap_next = CAP_W'(1);
            end
            else if (cfg_wdata > CAP_MAX)
            begin
                cap_next = CAP_MAX;
            end
            else
            begin
                cap_next = cfg_wdata;
            end
        end

        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= RESET_CAP;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    fcs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fcs_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cap       (cap_reg),
        .cfg_we    (cfg_we),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule : circular_fifo_with_search

`default_nettype wire

>>> sv/fcs_checker.sv
// ----------------------------------------------------------------------------
// fcs_checker
// Port-level checks for the circular fifo with search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcs_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire fcs_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire fcs_pkg::rsp_t rsp
);

    import fcs_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // clear with a free output slot answers next cycle with an empty queue
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.operation == OP_CLEAR && !rsp_valid
        |=> rsp_valid && rsp.status == ST_OK && rsp.count == '0)
        else $error("clear did not answer with an empty queue");

    // enqueue with a free output slot answers next cycle, ok or full
    a_enqueue: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.operation == OP_ENQUEUE && !rsp_valid
        |=> rsp_valid && rsp.data == '0 && rsp.count != '0
            && (rsp.status == ST_OK || rsp.status == ST_FULL))
        else $error("enqueue response wrong");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0 && rsp.data == '0)
        else $error("empty status with stored words or data");

endmodule : fcs_checker

bind circular_fifo_with_search fcs_checker u_fcs_checker (.*);

`default_nettype wire
